FILE: design/fwt_pkg.sv
// Shared types and codes for the wait-tracking FIFO.
// No dependencies; imported by every module of the block.
package fwt_pkg;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] entry_id;
    } in_t;

    typedef struct packed {
        logic [15:0] served_id;
        logic [31:0] served_wait;
        logic        served_valid;
        logic [1:0]  status;
        logic [6:0]  occupancy;
        logic [31:0] longest_wait;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // input transfer this cycle: latch item, read head entry
        logic exec;     // apply the latched item and load the result register
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free; // result register empty or being drained this cycle
    } dp_stat_t;

endpackage

FILE: design/fwt_ctrl.sv
// Controller for the wait-tracking FIFO: two-state sequencer per item.
// Depends on fwt_pkg.
module fwt_ctrl
    import fwt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  dp_stat_t stat,
    output ctl_t     ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign cmd_ready  = (state_reg == S_IDLE);
    assign ctl.accept = cmd_valid && cmd_ready;
    assign ctl.exec   = (state_reg == S_EXEC) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/fwt_datapath.sv
// Datapath for the wait-tracking FIFO: entry memories, pointers, tick counter,
// longest-wait register and the result register. Depends on fwt_pkg.
module fwt_datapath
    import fwt_pkg::*;
#(
    parameter int DEPTH   = 64,
    parameter int ID_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_t      cmd,
    input  ctl_t     ctl,
    output dp_stat_t stat,
    output logic     res_valid,
    input  logic     res_ready,
    output out_t     res
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (ID_BITS < 16) ? ID_BITS : 16;

    logic [SW-1:0] id_mem [DEPTH];
    logic [31:0]   arr_mem [DEPTH];

    logic [SW-1:0] id_rd_reg;
    logic [31:0]   arr_rd_reg;
    logic [1:0]    op_reg;
    logic [SW-1:0] id_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   tick_reg, tick_next;
    logic [31:0]   max_reg, max_next;
    logic          res_valid_reg, res_valid_next;
    out_t          res_reg, res_next;

    logic          mem_we;
    logic [31:0]   wait_val;

    assign stat.out_free = !res_valid_reg || res_ready;
    assign res_valid     = res_valid_reg;
    assign res           = res_reg;
    assign wait_val      = tick_reg - arr_rd_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        tick_next  = tick_reg;
        max_next   = max_reg;
        mem_we     = 1'b0;

        res_next              = '0;
        res_next.status       = ST_OK;

        case (op_reg)
            OP_ENQ:
            begin
                if (count_reg == CW'(DEPTH))
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    mem_we     = ctl.exec;
                    tail_next  = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEQ:
            begin
                if (count_reg == '0)
                begin
                    res_next.status = ST_EMPTY;
                end
                else
                begin
                    res_next.served_id    = 16'(id_rd_reg);
                    res_next.served_wait  = wait_val;
                    res_next.served_valid = 1'b1;
                    if (wait_val > max_reg)
                    begin
                        max_next = wait_val;
                    end
                    head_next  = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_TICK:
            begin
                tick_next = tick_reg + 32'd1;
            end
            default:
            begin
                // unused code: no change
            end
        endcase

        res_next.occupancy    = 7'(count_next);
        res_next.longest_wait = max_next;

        if (ctl.exec)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // entry memories: head read launched at input transfer, write at execute
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[tail_reg]  <= id_reg;
            arr_mem[tail_reg] <= tick_reg;
        end
        if (ctl.accept)
        begin
            id_rd_reg  <= id_mem[head_reg];
            arr_rd_reg <= arr_mem[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            op_reg <= cmd.op;
            id_reg <= SW'(cmd.entry_id);
        end
        if (ctl.exec)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            tick_reg      <= '0;
            max_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.exec)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
                tick_reg  <= tick_next;
                max_reg   <= max_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

FILE: design/fifo_with_wait_tracking_top.sv
// Wait-tracking FIFO top level. The input transfer moves the controller to its
// execute state, which loads the result register and sets result valid. A new
// item is taken only once the last is executed, as the head entry is read into
// a register at input transfer; an item stalls in the execute state while the
// result register is full and not being drained. Reset clears pointers, count,
// tick counter, longest wait and result valid; entry memories are not cleared.
// Depends on fwt_pkg, fwt_ctrl, fwt_datapath.
module fifo_with_wait_tracking_top
    import fwt_pkg::*;
#(
    parameter int DEPTH   = 64,
    parameter int ID_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  in_t  cmd,
    output logic res_valid,
    input  logic res_ready,
    output out_t res
);

    ctl_t     ctl;
    dp_stat_t stat;

    fwt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    fwt_datapath #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .stat      (stat),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

FILE: tb/sv/fwt_result_check.sv
`timescale 1ns / 1ps
// Checker for the wait-tracking FIFO: watches both channels and predicts each result.
// It compares every result transfer with the oldest prediction. Depends on fwt_pkg.
module fwt_result_check
    import fwt_pkg::*;
#(
    parameter int DEPTH   = 64,
    parameter int ID_BITS = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  logic cmd_ready,
    input  in_t  cmd,
    input  logic res_valid,
    input  logic res_ready,
    input  out_t res,
    output int   errors,
    output int   outstanding
);

    logic [15:0] id_mem      [DEPTH];
    logic [31:0] arrival_mem [DEPTH];
    logic [31:0] tick_cnt;
    logic [31:0] peak_wait;
    int          head;
    int          tail;
    int          count;
    out_t        pending_results[$];

    // Applies one item to the shadow queue and returns the result it causes.
    function automatic out_t serve_item(in_t item);
        out_t        r;
        logic [15:0] id_mask;
        r = '0;
        id_mask = (ID_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ID_BITS) - 32'd1);
        r.status = ST_OK;
        case (item.op)
            OP_ENQ:
            begin
                if (count >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    id_mem[tail] = item.entry_id & id_mask;
                    arrival_mem[tail] = tick_cnt;
                    tail = (tail == DEPTH - 1) ? 0 : tail + 1;
                    count++;
                end
            end
            OP_DEQ:
            begin
                if (count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.served_id = id_mem[head];
                    r.served_wait = tick_cnt - arrival_mem[head];
                    r.served_valid = 1'b1;
                    if (r.served_wait > peak_wait)
                        peak_wait = r.served_wait;
                    head = (head == DEPTH - 1) ? 0 : head + 1;
                    count--;
                end
            end
            OP_TICK:
                tick_cnt = tick_cnt + 32'd1;
            default:
                ;
        endcase
        r.occupancy = 7'(count);
        r.longest_wait = peak_wait;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        logic bad;
        if (!rst_n)
        begin
            tick_cnt = '0;
            peak_wait = '0;
            head = 0;
            tail = 0;
            count = 0;
            pending_results.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            // result side first: a result never comes from the same edge's input
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with none expected: id=%h wait=%0d vld=%b st=%0d",
                                 $realtime, res.served_id, res.served_wait,
                                 res.served_valid, res.status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    bad = (res.served_id !== want.served_id)
                       || (res.served_wait !== want.served_wait)
                       || (res.served_valid !== want.served_valid)
                       || (res.status !== want.status)
                       || (res.occupancy !== want.occupancy)
                       || (res.longest_wait !== want.longest_wait);
                    if (bad)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: mismatch exp id=%h wait=%0d vld=%b st=%0d occ=%0d max=%0d",
                                     $realtime, want.served_id, want.served_wait,
                                     want.served_valid, want.status, want.occupancy,
                                     want.longest_wait);
                            $display("%0t:          got id=%h wait=%0d vld=%b st=%0d occ=%0d max=%0d",
                                     $realtime, res.served_id, res.served_wait,
                                     res.served_valid, res.status, res.occupancy,
                                     res.longest_wait);
                        end
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                pending_results.push_back(serve_item(cmd));
            outstanding = pending_results.size();
        end
    end

endmodule

FILE: tb/sv/fifo_with_wait_tracking_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the wait-tracking FIFO: clock, reset, command stimulus and result stalls.
// Depends on fwt_pkg, fifo_with_wait_tracking_top and fwt_result_check.
module fifo_with_wait_tracking_top_tb;
    import fwt_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;   // unused code, changes no block state but still gives a result
    localparam int DEPTH = 64;
    localparam int ITEM_GOAL = 1600;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    in_t  cmd       = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    out_t res;

    int   errors;
    int   outstanding;
    int   sent = 0;
    bit   tx_quiet = 1'b0;
    int   rx_hold = 0;

    fifo_with_wait_tracking_top #(.DEPTH(DEPTH), .ID_BITS(16)) u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    fwt_result_check #(.DEPTH(DEPTH), .ID_BITS(16)) u_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side stalls: mostly short, now and then long, with long ready stretches.
    always @(negedge clk)
    begin
        int r;
        if (rx_hold > 0)
            rx_hold--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                res_ready <= 1'b1;
                rx_hold = $urandom_range(0, 7);
            end
            else if (r < 60)
            begin
                res_ready <= 1'b1;
                rx_hold = $urandom_range(50, 200);
            end
            else if (r < 88)
            begin
                res_ready <= 1'b0;
                rx_hold = $urandom_range(0, 2);
            end
            else if (r < 98)
            begin
                res_ready <= 1'b0;
                rx_hold = $urandom_range(3, 12);
            end
            else
            begin
                res_ready <= 1'b0;
                rx_hold = $urandom_range(30, 80);
            end
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_t make_cmd(logic [1:0] op, logic [15:0] id);
        in_t c;
        c.op = op;
        c.entry_id = id;
        return c;
    endfunction

    // Called and returns at a falling edge; valid stays up across back-to-back transfers.
    task automatic send_cmd(in_t c);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        @(negedge clk);
        if (c.op != OP_NOP)
            sent++;
    endtask

    task automatic send_random(logic [1:0] op);
        send_cmd(make_cmd(op, 16'($urandom_range(0, 65535))));
    endtask

    // Hold off the sender until every result is back.
    task automatic drain_pause();
        cmd_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int r;
        int n;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: no-op, empty dequeue, idle tick, id extremes, waits, zero wait
        send_cmd(make_cmd(OP_NOP, 16'h0000));
        send_cmd(make_cmd(OP_DEQ, 16'h0000));
        send_cmd(make_cmd(OP_TICK, 16'h0000));
        send_cmd(make_cmd(OP_ENQ, 16'h0000));
        send_cmd(make_cmd(OP_ENQ, 16'hFFFF));
        send_cmd(make_cmd(OP_TICK, 16'hFFFF));
        send_cmd(make_cmd(OP_ENQ, 16'hA5A5));
        send_cmd(make_cmd(OP_TICK, 16'h1234));
        send_cmd(make_cmd(OP_TICK, 16'h0000));
        send_cmd(make_cmd(OP_DEQ, 16'hFFFF));
        send_cmd(make_cmd(OP_DEQ, 16'h0000));
        send_cmd(make_cmd(OP_NOP, 16'hFFFF));
        send_cmd(make_cmd(OP_DEQ, 16'h5555));
        send_cmd(make_cmd(OP_DEQ, 16'h0000));
        send_cmd(make_cmd(OP_ENQ, 16'h5A5A));
        send_cmd(make_cmd(OP_DEQ, 16'h0000));
        send_cmd(make_cmd(OP_TICK, 16'hFFFF));
        send_cmd(make_cmd(OP_DEQ, 16'hFFFF));
        drain_pause();

        while (sent < ITEM_GOAL)
        begin
            tx_quiet = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            if (r < 6)
            begin
                // mixed traffic
                n = $urandom_range(20, 80);
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        send_random(OP_ENQ);
                    else if (r < 74)
                        send_random(OP_DEQ);
                    else if (r < 97)
                        send_random(OP_TICK);
                    else
                        send_random(OP_NOP);
                end
            end
            else if (r < 8)
            begin
                // fill past full so the last enqueues are dropped
                n = $urandom_range(DEPTH + 2, DEPTH + 8);
                repeat (n)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_random(OP_TICK);
                    send_random(OP_ENQ);
                end
            end
            else if (r < 9)
            begin
                // drain past empty
                n = $urandom_range(DEPTH + 2, DEPTH + 8);
                repeat (n)
                begin
                    if ($urandom_range(0, 4) == 0)
                        send_random(OP_TICK);
                    send_random(OP_DEQ);
                end
            end
            else
                drain_pause();
        end
        cmd_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
